FILE: design/sfq_pkg.sv
// ----------------------------------------------------------------------------
// sfq_pkg: shared types and constants of the sortable queue
// Holds the beat formats of both channels, the entry format of the store,
// the operation and status codes and the controller states.
// ----------------------------------------------------------------------------
package sfq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_POP  = 2'd1,
		ACT_SORT = 2'd2,
		ACT_PEEK = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		action_t            action;
		logic signed [15:0] key_in;
		logic signed [31:0] value_in;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic signed [15:0] key_out;
		logic signed [31:0] value_out;
		logic [4:0]         count;
	} result_t;

	typedef struct packed {
		logic signed [15:0] key;
		logic signed [31:0] value;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SORT_ORD,
		ST_SORT_OLD,
		ST_SORT_SCAN,
		ST_SORT_SW1,
		ST_SORT_SW2,
		ST_FINISH
	} state_t;

endpackage

FILE: design/sortable_fifo_queue_top.sv
// ----------------------------------------------------------------------------
// sortable_fifo_queue_top: bounded (key, value) queue with in-place sort
// Pushes enter at the head, pops take the oldest entry at the tail, peeks
// return the head and a sort orders keys ascending from head to tail.
// ----------------------------------------------------------------------------
// Use of the block:
// An operation arrives as one beat on the item channel (item_valid,
// item_ready, item) and produces exactly one beat on the result channel
// (result_valid, result_ready, result) carrying a status, the popped or
// peeked entry and the entry count after the operation.
// The block works on one operation at a time. A push, a push to a full
// queue and a pop or peek on an empty queue go from ST_EXEC straight to
// ST_FINISH; a pop or peek that reads the store passes through ST_READ. A
// sort is a selection sort run through the single read port of the entry
// store: for each outer position p (0 to count-2) it reads the entry at p,
// scans the remaining entries for the smallest key, writes that entry to p
// and, when a swap is needed, writes the old entry of p to its slot.
// item_ready is high only when the controller is idle.
// The result sits in an output register; when the receiver stalls, the
// finished result waits in the controller until that register is free, and
// no new beat is accepted meanwhile.
// Reset clears the head pointer and the entry count, so the queue comes up
// empty; the store itself is not cleared, as only live entries are read.
// ----------------------------------------------------------------------------
module sortable_fifo_queue_top
	import sfq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	state_t            state_q, state_d;
	item_t             item_q;
	logic [IDX_W-1:0]  head_q, head_d;
	logic [CNT_W-1:0]  count_q, count_d;

	// Sort bookkeeping: list positions, the entry taken at the outer
	// position and the smallest entry found so far with its slot.
	logic [CNT_W-1:0]  outer_q, outer_d;
	logic [CNT_W-1:0]  inner_q, inner_d;
	entry_t            outer_ent_q, outer_ent_d;
	entry_t            min_ent_q, min_ent_d;
	logic [IDX_W-1:0]  min_slot_q, min_slot_d;

	// Pending result, held until the output register can take it.
	status_t           res_status_q, res_status_d;
	entry_t            res_ent_q, res_ent_d;

	result_t           out_q;
	logic              out_valid_q;
	logic              out_free;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	logic [IDX_W-1:0]  rd_addr;
	entry_t            rd_data;

	logic [IDX_W-1:0]  outer_slot;
	logic [IDX_W-1:0]  inner_slot;
	logic [CNT_W-1:0]  inner_next;
	logic [CNT_W-1:0]  outer_next;

	sfq_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// The slot of list position p is (head + p) modulo the depth; the
	// depth is a power of two, so the sum simply wraps.
	assign outer_slot = head_q + outer_q[IDX_W-1:0];
	assign inner_slot = head_q + inner_q[IDX_W-1:0];
	assign inner_next = inner_q + CNT_W'(1);
	assign outer_next = outer_q + CNT_W'(1);

	assign out_free     = !out_valid_q || result_ready;
	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		count_d      = count_q;
		outer_d      = outer_q;
		inner_d      = inner_q;
		outer_ent_d  = outer_ent_q;
		min_ent_d    = min_ent_q;
		min_slot_d   = min_slot_q;
		res_status_d = res_status_q;
		res_ent_d    = res_ent_q;
		wr_en        = 1'b0;
		wr_addr      = outer_slot;
		wr_data      = min_ent_q;
		rd_addr      = outer_slot;

		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_EXEC;
				end
			end

			ST_EXEC: begin
				res_status_d = STAT_OK;
				res_ent_d    = '0;
				case (item_q.action)
					ACT_PUSH: begin
						state_d = ST_FINISH;
						if (count_q == CNT_W'(DEPTH)) begin
							res_status_d = STAT_FULL;
						end else begin
							head_d          = head_q - IDX_W'(1);
							count_d         = count_q + CNT_W'(1);
							wr_en           = 1'b1;
							wr_addr         = head_q - IDX_W'(1);
							wr_data.key     = item_q.key_in;
							wr_data.value   = item_q.value_in;
						end
					end
					ACT_POP: begin
						if (count_q == '0) begin
							res_status_d = STAT_EMPTY;
							state_d      = ST_FINISH;
						end else begin
							rd_addr = head_q + IDX_W'(count_q - CNT_W'(1));
							state_d = ST_READ;
						end
					end
					ACT_SORT: begin
						outer_d = '0;
						if (count_q < CNT_W'(2)) begin
							state_d = ST_FINISH;
						end else begin
							state_d = ST_SORT_ORD;
						end
					end
					default: begin
						if (count_q == '0) begin
							res_status_d = STAT_EMPTY;
							state_d      = ST_FINISH;
						end else begin
							rd_addr = head_q;
							state_d = ST_READ;
						end
					end
				endcase
			end

			ST_READ: begin
				res_ent_d = rd_data;
				if (item_q.action == ACT_POP) begin
					count_d = count_q - CNT_W'(1);
				end
				state_d = ST_FINISH;
			end

			ST_SORT_ORD: begin
				rd_addr = outer_slot;
				inner_d = outer_next;
				state_d = ST_SORT_OLD;
			end

			ST_SORT_OLD: begin
				outer_ent_d = rd_data;
				min_ent_d   = rd_data;
				min_slot_d  = outer_slot;
				rd_addr     = inner_slot;
				state_d     = ST_SORT_SCAN;
			end

			ST_SORT_SCAN: begin
				// Strict compare keeps the first minimum nearest the head.
				if ($signed(min_ent_q.key) > $signed(rd_data.key)) begin
					min_ent_d  = rd_data;
					min_slot_d = inner_slot;
				end
				if (inner_next < count_q) begin
					inner_d = inner_next;
					rd_addr = head_q + inner_next[IDX_W-1:0];
				end else begin
					state_d = ST_SORT_SW1;
				end
			end

			ST_SORT_SW1: begin
				wr_en   = 1'b1;
				wr_addr = outer_slot;
				wr_data = min_ent_q;
				if (min_slot_q != outer_slot) begin
					state_d = ST_SORT_SW2;
				end else begin
					outer_d = outer_next;
					state_d = (outer_next + CNT_W'(1) < count_q) ? ST_SORT_ORD : ST_FINISH;
				end
			end

			ST_SORT_SW2: begin
				wr_en   = 1'b1;
				wr_addr = min_slot_q;
				wr_data = outer_ent_q;
				outer_d = outer_next;
				state_d = (outer_next + CNT_W'(1) < count_q) ? ST_SORT_ORD : ST_FINISH;
			end

			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		outer_q      <= outer_d;
		inner_q      <= inner_d;
		outer_ent_q  <= outer_ent_d;
		min_ent_q    <= min_ent_d;
		min_slot_q   <= min_slot_d;
		res_status_q <= res_status_d;
		res_ent_q    <= res_ent_d;
		if (state_q == ST_FINISH && out_free) begin
			out_q.status    <= res_status_q;
			out_q.key_out   <= res_ent_q.key;
			out_q.value_out <= res_ent_q.value;
			out_q.count     <= 5'(count_q);
		end
	end

endmodule

FILE: design/sfq_store.sv
// ----------------------------------------------------------------------------
// sfq_store: entry store of the sortable queue
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address.
// ----------------------------------------------------------------------------
module sfq_store
	import sfq_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
